// ===== hw/rtl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants for the string intern table.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int TABLE_BYTES_DEF    = 4096;
    localparam int MAX_STRING_LEN_DEF = 255;

    localparam int CH_W     = 8;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 12;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd4;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_COPY = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

// ===== hw/rtl/sit_ram.sv =====
// ----------------------------------------------------------------------------
// sit_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/string_intern_table_core.sv =====
// ----------------------------------------------------------------------------
// string_intern_table_core
// String interning table: collects a zero-terminated query, scans the packed
// string store for an exact match, and optionally appends the query.
// ----------------------------------------------------------------------------
// Query bytes are taken one per cycle while the table is idle and written to
// a query RAM; bytes past MAX_STRING_LEN are dropped and flag an overflow.
// They give no response. The zero byte starts a scan of the string store RAM,
// one stored byte per cycle from offset 0 up to the fill index; a match ends
// the scan at that string's terminator. An insert that fits then copies the
// query and its terminator into the store at one byte per cycle. The DONE
// state hands the response to the output register once that is free. An
// over-long query skips the scan and answers too-long from the DONE state.
// No clearing pass is needed after reset.
module string_intern_table_core #(
    parameter int TABLE_BYTES    = sit_pkg::TABLE_BYTES_DEF,
    parameter int MAX_STRING_LEN = sit_pkg::MAX_STRING_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic [sit_pkg::CH_W-1:0]      i_ch,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sit_pkg::STATUS_W-1:0]  o_status,
    output logic [sit_pkg::POS_W-1:0]     o_position
);

    localparam int AW  = $clog2(TABLE_BYTES);
    localparam int FW  = $clog2(TABLE_BYTES + 1);
    localparam int QLW = $clog2(MAX_STRING_LEN + 1);
    localparam int QAW = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1;
    localparam int SW  = ((FW > QLW) ? FW : QLW) + 1;

    sit_pkg::t_state r_state, n_state;

    logic [FW-1:0]  r_fill, n_fill;
    logic [QLW-1:0] r_qlen, n_qlen;
    logic           r_ovf, n_ovf;
    logic           r_cmd, n_cmd;
    logic [FW-1:0]  r_ptr, n_ptr;
    logic [FW-1:0]  r_start, n_start;
    logic [QLW-1:0] r_qi, n_qi;
    logic           r_miss, n_miss;

    logic [sit_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [sit_pkg::POS_W-1:0]    r_res_pos, n_res_pos;

    logic                         r_out_valid, n_out_valid;
    logic [sit_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [sit_pkg::POS_W-1:0]    r_out_pos, n_out_pos;

    logic                     st_we;
    logic [AW-1:0]            st_waddr;
    logic [sit_pkg::CH_W-1:0] st_wdata;
    logic [sit_pkg::CH_W-1:0] st_rdata;

    logic                     q_we;
    logic [sit_pkg::CH_W-1:0] q_rdata;

    logic accept;
    logic fits;

    assign o_ready = (r_state == sit_pkg::S_IDLE);
    assign accept  = i_valid && o_ready;
    assign fits    = (SW'(r_fill) + SW'(r_qlen) + SW'(1)) <= SW'(TABLE_BYTES);
    assign q_we    = accept && (i_ch != '0) && (r_qlen < QLW'(MAX_STRING_LEN));

    sit_ram #(
        .WIDTH(sit_pkg::CH_W),
        .DEPTH(TABLE_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(n_ptr[AW-1:0]),
        .o_rdata(st_rdata)
    );

    sit_ram #(
        .WIDTH(sit_pkg::CH_W),
        .DEPTH(MAX_STRING_LEN)
    ) u_query (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(QAW'(r_qlen)),
        .i_wdata(i_ch),
        .i_raddr(QAW'(n_qi)),
        .o_rdata(q_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_qlen       = r_qlen;
        n_ovf        = r_ovf;
        n_cmd        = r_cmd;
        n_ptr        = r_ptr;
        n_start      = r_start;
        n_qi         = r_qi;
        n_miss       = r_miss;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        st_we        = 1'b0;
        st_waddr     = AW'(r_fill + FW'(r_qi));
        st_wdata     = q_rdata;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            sit_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_ch != '0) begin
                        if (r_qlen < QLW'(MAX_STRING_LEN)) begin
                            n_qlen = r_qlen + QLW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (r_ovf) begin
                        n_res_status = sit_pkg::ST_TOO_LONG;
                        n_res_pos    = '0;
                        n_state      = sit_pkg::S_DONE;
                    end else begin
                        n_cmd   = i_command;
                        n_ptr   = '0;
                        n_start = '0;
                        n_qi    = '0;
                        n_miss  = 1'b0;
                        n_state = sit_pkg::S_SCAN;
                    end
                end
            end
            sit_pkg::S_SCAN: begin
                if (r_ptr == r_fill) begin
                    n_res_pos = '0;
                    if (r_cmd == sit_pkg::CMD_LOOKUP) begin
                        n_res_status = sit_pkg::ST_NOT_FOUND;
                        n_state      = sit_pkg::S_DONE;
                    end else if (!fits) begin
                        n_res_status = sit_pkg::ST_FULL;
                        n_state      = sit_pkg::S_DONE;
                    end else begin
                        n_qi    = '0;
                        n_state = sit_pkg::S_COPY;
                    end
                end else if (st_rdata == '0) begin
                    if (!r_miss && (r_qi == r_qlen)) begin
                        n_res_status = sit_pkg::ST_FOUND;
                        n_res_pos    = sit_pkg::POS_W'(r_start);
                        n_state      = sit_pkg::S_DONE;
                    end else begin
                        n_ptr   = r_ptr + FW'(1);
                        n_start = r_ptr + FW'(1);
                        n_qi    = '0;
                        n_miss  = 1'b0;
                    end
                end else begin
                    if ((r_qi >= r_qlen) || (st_rdata != q_rdata)) begin
                        n_miss = 1'b1;
                    end
                    n_qi  = r_qi + QLW'(1);
                    n_ptr = r_ptr + FW'(1);
                end
            end
            sit_pkg::S_COPY: begin
                st_we = 1'b1;
                if (r_qi == r_qlen) begin
                    st_wdata     = '0;
                    n_fill       = FW'(SW'(r_fill) + SW'(r_qlen) + SW'(1));
                    n_res_status = sit_pkg::ST_INSERTED;
                    n_res_pos    = sit_pkg::POS_W'(r_fill);
                    n_state      = sit_pkg::S_DONE;
                end else begin
                    n_qi = r_qi + QLW'(1);
                end
            end
            sit_pkg::S_DONE: begin
                n_qlen = '0;
                n_ovf  = 1'b0;
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_pos    = r_res_pos;
                    n_state      = sit_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sit_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sit_pkg::S_IDLE;
            r_fill      <= '0;
            r_qlen      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
            r_qi        <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_qlen      <= n_qlen;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_ptr       <= n_ptr;
            r_qi        <= n_qi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_start      <= n_start;
        r_miss       <= n_miss;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_position = r_out_pos;

endmodule
